// ----- rtl/core/u8cm_pkg.sv -----
// Shared types, constants and functions for the UTF-8 case mapping transcoder.
// Used by u8cm_front, u8cm_queue, u8cm_back and the top level; no dependencies.
package u8cm_pkg;

  localparam int unsigned SCALAR_W = 21;
  localparam int unsigned SLOTS    = 4;

  localparam logic CASE_UPPER = 1'b0;
  localparam logic CASE_LOWER = 1'b1;

  // Lead byte classes: how many continuation bytes a lead opens.
  localparam logic [1:0] NEED_NONE  = 2'd0;
  localparam logic [1:0] NEED_ONE   = 2'd1;
  localparam logic [1:0] NEED_TWO   = 2'd2;
  localparam logic [1:0] NEED_THREE = 2'd3;

  // One input transaction's worth of scalars, in emission order.
  typedef struct packed {
    logic [SLOTS-1:0][SCALAR_W-1:0] scalar;
    logic [1:0]                     last_idx;
    logic                           stream_end;
  } u8cm_rec_t;

  function automatic logic [SCALAR_W-1:0] to_upper(input logic [SCALAR_W-1:0] c);
    logic [SCALAR_W-1:0] r;
    r = c;
    if (c < 21'h80) begin
      if (c inside {[21'h61:21'h7A]}) r = c - 21'd32;
    end else if ((c inside {[21'hE0:21'hFE]}) && (c != 21'hF7)) begin
      r = c - 21'd32;
    end else if (c == 21'hFF) begin
      r = 21'h178;
    end else if (c == 21'hB5) begin
      r = 21'h39C;
    end else if (c inside {[21'h100:21'h137]}) begin
      r = c[0] ? c - 21'd1 : c;
    end else if (c inside {[21'h139:21'h148]}) begin
      r = c[0] ? c : c - 21'd1;
    end else if (c inside {[21'h14A:21'h177]}) begin
      r = c[0] ? c - 21'd1 : c;
    end else if (c inside {[21'h179:21'h17E]}) begin
      r = c[0] ? c : c - 21'd1;
    end else if (c inside {[21'h3B1:21'h3C1]}) begin
      r = c - 21'd32;
    end else if (c == 21'h3C2) begin
      r = 21'h3A3;
    end else if (c inside {[21'h3C3:21'h3CB]}) begin
      r = c - 21'd32;
    end else if (c inside {[21'h430:21'h44F]}) begin
      r = c - 21'd32;
    end else if (c inside {[21'h450:21'h45F]}) begin
      r = c - 21'd80;
    end
    return r;
  endfunction

  function automatic logic [SCALAR_W-1:0] to_lower(input logic [SCALAR_W-1:0] c);
    logic [SCALAR_W-1:0] r;
    r = c;
    if (c < 21'h80) begin
      if (c inside {[21'h41:21'h5A]}) r = c + 21'd32;
    end else if ((c inside {[21'hC0:21'hDE]}) && (c != 21'hD7)) begin
      r = c + 21'd32;
    end else if (c == 21'h178) begin
      r = 21'hFF;
    end else if (c inside {[21'h100:21'h137]}) begin
      r = c[0] ? c : c + 21'd1;
    end else if (c inside {[21'h139:21'h148]}) begin
      r = c[0] ? c + 21'd1 : c;
    end else if (c inside {[21'h14A:21'h177]}) begin
      r = c[0] ? c : c + 21'd1;
    end else if (c inside {[21'h179:21'h17E]}) begin
      r = c[0] ? c + 21'd1 : c;
    end else if (c inside {[21'h391:21'h3A1]}) begin
      r = c + 21'd32;
    end else if (c inside {[21'h3A3:21'h3AB]}) begin
      r = c + 21'd32;
    end else if (c inside {[21'h410:21'h42F]}) begin
      r = c + 21'd32;
    end else if (c inside {[21'h400:21'h40F]}) begin
      r = c + 21'd80;
    end
    return r;
  endfunction

  // Index of the last UTF-8 byte needed for scalar c.
  function automatic logic [1:0] enc_last(input logic [SCALAR_W-1:0] c);
    logic [1:0] n;
    if (c < 21'h80)         n = 2'd0;
    else if (c < 21'h800)   n = 2'd1;
    else if (c < 21'h10000) n = 2'd2;
    else                    n = 2'd3;
    return n;
  endfunction

  // Byte k of the UTF-8 form of c, whose last byte index is n.
  function automatic logic [7:0] enc_byte(input logic [SCALAR_W-1:0] c,
                                          input logic [1:0] n, input logic [1:0] k);
    logic [7:0] b;
    b = {2'b10, c[5:0]};
    case (n)
      2'd0: b = c[7:0];
      2'd1: begin
        if (k == 2'd0) b = {3'b110, c[10:6]};
      end
      2'd2: begin
        if (k == 2'd0)      b = {4'b1110, c[15:12]};
        else if (k == 2'd1) b = {2'b10, c[11:6]};
      end
      default: begin
        if (k == 2'd0)      b = {5'b11110, c[20:18]};
        else if (k == 2'd1) b = {2'b10, c[17:12]};
        else if (k == 2'd2) b = {2'b10, c[11:6]};
      end
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/core/u8cm_front.sv -----
// Front end: accepts input bytes, runs the lenient UTF-8 decoder state and
// pushes one record of up to four scalars per productive transaction. Uses u8cm_pkg.
module u8cm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic [7:0]           in_byte,
  input  logic                 in_end,
  output logic                 push_o,
  output u8cm_pkg::u8cm_rec_t  rec_o
);

  logic [7:0]  lead_r, lead_nxt;
  logic [1:0]  need_r, need_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic [20:0] pv_r, pv_nxt;
  logic [7:0]  hc_r [2];
  logic [7:0]  hc_nxt [2];

  logic        is_cont;
  logic [1:0]  lead_need;
  logic [20:0] lead_bits;
  logic [20:0] pv_new;
  logic [2:0]  seen_inc;
  logic        complete;
  logic        flush_en;
  logic [1:0]  flush_k;
  logic        tail_en;
  logic [20:0] tail_val;
  logic [2:0]  count;

  always_comb begin
    is_cont   = (in_byte[7:6] == 2'b10);
    lead_need = u8cm_pkg::NEED_NONE;
    lead_bits = '0;
    if (in_byte[7:5] == 3'b110) begin
      lead_need = u8cm_pkg::NEED_ONE;
      lead_bits = {16'd0, in_byte[4:0]};
    end else if (in_byte[7:4] == 4'b1110) begin
      lead_need = u8cm_pkg::NEED_TWO;
      lead_bits = {17'd0, in_byte[3:0]};
    end else if (in_byte[7:3] == 5'b11110) begin
      lead_need = u8cm_pkg::NEED_THREE;
      lead_bits = {18'd0, in_byte[2:0]};
    end
    pv_new   = {pv_r[14:0], in_byte[5:0]};
    seen_inc = {1'b0, seen_r} + 3'd1;
    complete = (seen_inc >= {1'b0, need_r});

    lead_nxt  = lead_r;
    need_nxt  = need_r;
    seen_nxt  = seen_r;
    pv_nxt    = pv_r;
    hc_nxt    = hc_r;
    flush_en  = 1'b0;
    flush_k   = 2'd0;
    tail_en   = 1'b0;
    tail_val  = {13'd0, in_byte};

    if ((need_r != u8cm_pkg::NEED_NONE) && is_cont) begin
      if (complete) begin
        tail_en  = 1'b1;
        tail_val = pv_new;
        need_nxt = u8cm_pkg::NEED_NONE;
        seen_nxt = 2'd0;
        pv_nxt   = '0;
      end else begin
        hc_nxt[seen_r[0]] = in_byte;
        if (in_end) begin
          flush_en = 1'b1;
          flush_k  = seen_inc[1:0];
          need_nxt = u8cm_pkg::NEED_NONE;
          seen_nxt = 2'd0;
          pv_nxt   = '0;
        end else begin
          seen_nxt = seen_inc[1:0];
          pv_nxt   = pv_new;
        end
      end
    end else begin
      // broken sequence: lead and held continuations go out first
      if (need_r != u8cm_pkg::NEED_NONE) begin
        flush_en = 1'b1;
        flush_k  = seen_r;
      end
      if (in_end || (lead_need == u8cm_pkg::NEED_NONE)) begin
        tail_en  = 1'b1;
        need_nxt = u8cm_pkg::NEED_NONE;
        seen_nxt = 2'd0;
        pv_nxt   = '0;
      end else begin
        lead_nxt = in_byte;
        need_nxt = lead_need;
        seen_nxt = 2'd0;
        pv_nxt   = lead_bits;
      end
    end

    count = (flush_en ? (3'd1 + {1'b0, flush_k}) : 3'd0) + {2'd0, tail_en};

    rec_o.scalar[0]  = flush_en ? {13'd0, lead_r} : tail_val;
    rec_o.scalar[1]  = (flush_en && (flush_k >= 2'd1)) ? {13'd0, hc_nxt[0]} : tail_val;
    rec_o.scalar[2]  = (flush_en && (flush_k >= 2'd2)) ? {13'd0, hc_nxt[1]} : tail_val;
    rec_o.scalar[3]  = tail_val;
    rec_o.last_idx   = 2'(count - 3'd1);
    rec_o.stream_end = in_end;
    push_o           = in_fire && (count != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= '0;
      need_r <= u8cm_pkg::NEED_NONE;
      seen_r <= '0;
      pv_r   <= '0;
    end else if (in_fire) begin
      lead_r <= lead_nxt;
      need_r <= need_nxt;
      seen_r <= seen_nxt;
      pv_r   <= pv_nxt;
    end
  end

  // held continuation bytes are only read below seen_r
  always_ff @(posedge clk) begin
    if (in_fire) begin
      hc_r <= hc_nxt;
    end
  end

endmodule

// ----- rtl/core/u8cm_queue.sv -----
// Short register queue of scalar records between front and back end.
// Uses u8cm_pkg for the record type.
module u8cm_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  u8cm_pkg::u8cm_rec_t  rec_i,
  input  logic                 pop_i,
  output u8cm_pkg::u8cm_rec_t  rec_o,
  output logic                 full_o,
  output logic                 empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  u8cm_pkg::u8cm_rec_t mem [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push_i) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop_i) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push_i && !pop_i) cnt_nxt = cnt_r + 1'b1;
    else if (!push_i && pop_i) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem[wp_r] <= rec_i;
    end
  end

  assign rec_o   = mem[rp_r];
  assign full_o  = (cnt_r == CW'(DEPTH));
  assign empty_o = (cnt_r == '0);

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o)
    else $error("record pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o)
    else $error("record popped from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (push_i && !pop_i) |=> !empty_o)
    else $error("pushed record not visible");

endmodule

// ----- rtl/core/u8cm_back.sv -----
// Back end: case maps each queued scalar and streams its UTF-8 bytes, one per
// cycle while out_tready is high, through an output register. Uses u8cm_pkg.
module u8cm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 case_mode,
  input  u8cm_pkg::u8cm_rec_t  rec_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tlast,
  output logic [0:0]           out_tuser
);

  logic [1:0]  si_r, si_nxt;
  logic [1:0]  bi_r, bi_nxt;
  logic        vld_r, vld_nxt;
  logic [7:0]  byte_r;
  logic        run_last_r;
  logic        stream_last_r;

  logic        load;
  logic [20:0] scalar;
  logic [20:0] mapped;
  logic [1:0]  n_last;
  logic [7:0]  enc;
  logic        byte_last;
  logic        rec_last;

  always_comb begin
    load      = !empty_i && (!vld_r || out_tready);
    scalar    = rec_i.scalar[si_r];
    mapped    = (case_mode == u8cm_pkg::CASE_LOWER) ? u8cm_pkg::to_lower(scalar)
                                                    : u8cm_pkg::to_upper(scalar);
    n_last    = u8cm_pkg::enc_last(mapped);
    enc       = u8cm_pkg::enc_byte(mapped, n_last, bi_r);
    byte_last = (bi_r == n_last);
    rec_last  = byte_last && (si_r == rec_i.last_idx);

    si_nxt  = si_r;
    bi_nxt  = bi_r;
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
      bi_nxt  = byte_last ? 2'd0 : bi_r + 2'd1;
      if (rec_last)       si_nxt = 2'd0;
      else if (byte_last) si_nxt = si_r + 2'd1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
    pop_o = load && rec_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      si_r  <= '0;
      bi_r  <= '0;
      vld_r <= 1'b0;
    end else begin
      si_r  <= si_nxt;
      bi_r  <= bi_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r        <= enc;
      run_last_r    <= rec_last;
      stream_last_r <= rec_last && rec_i.stream_end;
    end
  end

  assign out_tvalid   = vld_r;
  assign out_tdata    = byte_r;
  assign out_tlast    = run_last_r;
  assign out_tuser[0] = stream_last_r;

endmodule

// ----- rtl/core/utf8_case_mapping_transcoder_unit.sv -----
// An input transaction reaches its first output byte through the queue write, then the
// output register; the bytes of one input byte then follow one per cycle while out_tready is high.
// Throughput: one input byte per cycle while the record queue has room; the back
// end's encoder sends one output byte per cycle while out_tready is high, 0 to 8 bytes per input byte.
// Reset (rst_n low, synchronous): decoder closed, queue empty, output invalid,
// case_mode back to upper case.
// Top level; instantiates u8cm_front, u8cm_queue and u8cm_back; uses u8cm_pkg.
module utf8_case_mapping_transcoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,   // case_mode
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_byte
  input  logic       in_tlast,    // stream_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tlast,   // run_last
  output logic [0:0] out_tuser    // [0] stream_last
);

  logic                case_mode_r;
  logic                in_fire;
  logic                push;
  logic                pop;
  logic                full;
  logic                empty;
  u8cm_pkg::u8cm_rec_t rec_in;
  u8cm_pkg::u8cm_rec_t rec_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_mode_r <= u8cm_pkg::CASE_UPPER;
    end else if (cfg_we) begin
      case_mode_r <= cfg_wdata;
    end
  end

  assign in_tready = !full;
  assign in_fire   = in_tvalid && in_tready;

  u8cm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .in_end  (in_tlast),
    .push_o  (push),
    .rec_o   (rec_in)
  );

  u8cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .rec_i   (rec_in),
    .pop_i   (pop),
    .rec_o   (rec_head),
    .full_o  (full),
    .empty_o (empty)
  );

  u8cm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .case_mode  (case_mode_r),
    .rec_i      (rec_head),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
